// ===== rtl/core/stt_pkg.sv =====
// stt_pkg: shared types and constants for the software timer table
// operation codes, command record passed from front to back, sizing defaults
// no dependencies
package stt_pkg;

	// field widths fixed by the item format
	localparam int OP_W = 3;
	localparam int SLOT_W = 4;
	localparam int TIME_W = 32;
	localparam int VALUE_W = 32;

	// slot field can address at most this many slots
	localparam int SLOT_SPAN = 1 << SLOT_W;

	// module parameter defaults
	localparam int TIMER_SLOTS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	// stream word widths, padded to whole bytes
	localparam int IN_DATA_BITS = SLOT_W + TIME_W + VALUE_W + 1;
	localparam int IN_DATA_W = ((IN_DATA_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = SLOT_W + VALUE_W;
	localparam int OUT_DATA_W = ((OUT_DATA_BITS + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 3'd0,
		OP_SETUP  = 3'd1,
		OP_START  = 3'd2,
		OP_MODIFY = 3'd3,
		OP_DELETE = 3'd4
	} op_t;

	// one decoded operation waiting for the back end
	typedef struct packed {
		op_t                kind;
		logic [SLOT_W-1:0]  slot;
		logic [TIME_W-1:0]  expiry;
		logic [VALUE_W-1:0] value;
		logic               handler;
	} cmd_t;

endpackage

// ===== rtl/core/software_timer_table.sv =====
// software_timer_table: top level of the one-shot timer table
// connects the input front end, the command queue and the execution back end
// depends on stt_pkg, stt_front, stt_queue, stt_back
//
// A table of one-shot timers on a 32-bit wrapping tick counter. Each input
// beat carries an operation in s_tuser (tick, setup, start, modify, delete)
// and its operands in s_tdata. Operations on slots outside the table and
// unknown codes are dropped at the input. Setup, start, modify and delete
// are applied by the back end while it is idle, without a scan. A tick
// first advances the counter, then one shared expiry comparator walks the
// slots in ascending order, one slot per cycle unless the output holds it
// off, through the single read port of the expiry and callback memories.
// The scan covers TIMER_SLOTS slots, at most the sixteen the slot field can
// address. Each expired slot with a handler yields one output beat with its
// slot and callback word; the final beat of a tick has m_tlast set. One
// result is held back until the next one (or the end of the scan) is known.
// A command queue of QUEUE_DEPTH entries (two by default) takes further
// beats while a scan runs; once it is full s_tready stays low until the
// back end, idle again after the scan, takes a command from the queue.
module software_timer_table
	import stt_pkg::*;
#(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// slot, expiry_time, callback_value, has_handler, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// operation
	input  logic [OP_W-1:0]       s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// fired_slot, fired_value, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// last
	output logic                  m_tlast
);

	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic pop_valid;
	cmd_t pop_cmd;
	logic pop;

	// input decode
	stt_front #(
		.TIMER_SLOTS(TIMER_SLOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_cmd  (push_cmd),
		.queue_full(queue_full)
	);

	// command queue
	stt_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop_valid(pop_valid),
		.pop_cmd  (pop_cmd),
		.pop      (pop)
	);

	// execution and output
	stt_back #(
		.TIMER_SLOTS(TIMER_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_cmd  (pop_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/core/stt_front.sv =====
// stt_front: input side of the timer table
// unpacks the input beat, drops operations that change nothing, feeds the queue
// depends on stt_pkg
module stt_front
	import stt_pkg::*;
#(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// slot, expiry_time, callback_value, has_handler, zero pad
	input  logic [IN_DATA_W-1:0] s_tdata,
	// operation
	input  logic [OP_W-1:0]      s_tuser,
	output logic                 push,
	output cmd_t                 push_cmd,
	input  logic                 queue_full
);

	localparam int SCAN = (TIMER_SLOTS < SLOT_SPAN) ? TIMER_SLOTS : SLOT_SPAN;

	logic slot_ok;
	logic keep;
	logic accept;

	// field unpacking
	always_comb begin
		push_cmd.kind    = op_t'(s_tuser);
		push_cmd.slot    = s_tdata[SLOT_W-1:0];
		push_cmd.expiry  = s_tdata[SLOT_W +: TIME_W];
		push_cmd.value   = s_tdata[SLOT_W+TIME_W +: VALUE_W];
		push_cmd.handler = s_tdata[SLOT_W+TIME_W+VALUE_W];
	end

	assign slot_ok = ({1'b0, push_cmd.slot} < (SLOT_W+1)'(SCAN));

	// classify: ticks always go, slot ops only for slots that exist
	always_comb begin
		case (s_tuser)
			OP_TICK:   keep = 1'b1;
			OP_SETUP:  keep = slot_ok;
			OP_START:  keep = slot_ok;
			OP_MODIFY: keep = slot_ok;
			OP_DELETE: keep = slot_ok;
			default:   keep = 1'b0;
		endcase
	end

	assign s_tready = !queue_full;
	assign accept = s_tvalid && s_tready;
	assign push = accept && keep;

	// a beat is never taken while the queue is full
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !queue_full)
		else $error("push into a full queue");

	// every accepted tick reaches the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == OP_TICK) |-> push)
		else $error("accepted tick was dropped");

	// unknown codes never reach the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser > OP_DELETE) |-> !push)
		else $error("unknown operation queued");

endmodule

// ===== rtl/core/stt_queue.sv =====
// stt_queue: short command queue between front and back of the timer table
// lets the input keep accepting while a tick scan is running
// depends on stt_pkg
module stt_queue
	import stt_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic pop_valid,
	output cmd_t pop_cmd,
	input  logic pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd = entry_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1))
			ptr_next = '0;
		else
			ptr_next = PTR_W'(p + 1'b1);
	endfunction

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= CNT_W'(count_q + 1'b1);
			else if (pop && !push)
				count_q <= CNT_W'(count_q - 1'b1);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== rtl/core/stt_back.sv =====
// stt_back: execution side of the timer table
// slot state, expiry and callback memories, tick scan and the output register
// depends on stt_pkg
module stt_back
	import stt_pkg::*;
#(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	input  cmd_t                  pop_cmd,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// fired_slot, fired_value, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// last
	output logic                  m_tlast
);

	localparam int SCAN = (TIMER_SLOTS < SLOT_SPAN) ? TIMER_SLOTS : SLOT_SPAN;
	localparam int IDX_W = (SCAN > 1) ? $clog2(SCAN) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN - 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EVAL  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [TIME_W-1:0] tick_count_q;
	logic [SCAN-1:0] armed_q;
	logic [SCAN-1:0] handler_q;

	logic [TIME_W-1:0]  expiry_mem [SCAN];
	logic [VALUE_W-1:0] value_mem [SCAN];
	logic [TIME_W-1:0]  rd_expiry_q;
	logic [VALUE_W-1:0] rd_value_q;

	logic               pend_valid_q;
	logic [IDX_W-1:0]   pend_slot_q;
	logic [VALUE_W-1:0] pend_value_q;

	logic               out_valid_q;
	logic [IDX_W-1:0]   out_slot_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_last_q;

	logic [IDX_W-1:0]  cmd_idx;
	logic [TIME_W-1:0] diff;
	logic              hit;
	logic              fire;
	logic              out_free;
	logic              stall;
	logic              load_out;
	logic              load_last;
	logic              is_tick;

	assign cmd_idx = pop_cmd.slot[IDX_W-1:0];
	assign is_tick = (pop_cmd.kind == OP_TICK);

	// wrap-safe expiry test on the slot under scan
	assign diff = rd_expiry_q - tick_count_q;
	assign hit = armed_q[idx_q] && diff[TIME_W-1];
	assign fire = hit && handler_q[idx_q];
	assign out_free = !out_valid_q || m_tready;
	assign stall = fire && pend_valid_q && !out_free;

	// sequencer: one command per cycle while idle, one slot per cycle during a tick unless the output stalls
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		pop       = 1'b0;
		load_out  = 1'b0;
		load_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					pop = 1'b1;
					if (is_tick) begin
						state_d = ST_EVAL;
						idx_d   = '0;
					end
				end
			end
			ST_EVAL: begin
				if (!stall) begin
					// a newer hit pushes the held one out, not last
					if (fire && pend_valid_q)
						load_out = 1'b1;
					if (idx_q == LAST_IDX)
						state_d = ST_FLUSH;
					else
						idx_d = IDX_W'(idx_q + 1'b1);
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					load_out  = 1'b1;
					load_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state, counter and per-slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			tick_count_q <= '0;
			armed_q      <= '0;
			handler_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (pop) begin
				case (pop_cmd.kind)
					OP_TICK:   tick_count_q <= tick_count_q + 1'b1;
					OP_SETUP:  handler_q[cmd_idx] <= pop_cmd.handler;
					OP_START:  armed_q[cmd_idx] <= 1'b1;
					OP_DELETE: armed_q[cmd_idx] <= 1'b0;
					default: begin
					end
				endcase
			end
			if (state_q == ST_EVAL && !stall) begin
				if (hit)
					armed_q[idx_q] <= 1'b0;
				if (fire)
					pend_valid_q <= 1'b1;
			end
			if (load_last)
				pend_valid_q <= 1'b0;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// held result and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL && !stall && fire) begin
			pend_slot_q  <= idx_q;
			pend_value_q <= rd_value_q;
		end
		if (load_out) begin
			out_slot_q  <= pend_slot_q;
			out_value_q <= pend_value_q;
			out_last_q  <= load_last;
		end
	end

	// expiry and callback memories, one write and one registered read
	always_ff @(posedge clk) begin
		if (pop && (pop_cmd.kind == OP_START || pop_cmd.kind == OP_MODIFY))
			expiry_mem[cmd_idx] <= pop_cmd.expiry;
		if (pop && pop_cmd.kind == OP_SETUP)
			value_mem[cmd_idx] <= pop_cmd.value;
		rd_expiry_q <= expiry_mem[idx_d];
		rd_value_q  <= value_mem[idx_d];
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_DATA_W'({out_value_q, SLOT_W'(out_slot_q)});

	// a held result only exists while a tick is being worked on
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (state_q == ST_EVAL || state_q == ST_FLUSH))
		else $error("held result outside a tick scan");

	// the queue is only drained between scans
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ST_IDLE)
		else $error("command popped during a scan");

	// each tick advances the counter by exactly one
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && is_tick) |=> tick_count_q == $past(tick_count_q) + 1'b1)
		else $error("tick counter did not advance by one");

	// an expired slot is disarmed once it has been passed
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && !stall && hit) |=> !armed_q[$past(idx_q)])
		else $error("expired slot still armed");

	// the scan index stays inside the table
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> idx_q <= LAST_IDX)
		else $error("scan index beyond last slot");

endmodule
